[rtl/hbil_pkg.sv]
// shared constants, codes and interface structs of the interval locator
`timescale 1ns / 1ps

package hbil_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  // search positions run below zero and past the table end during the hunt
  localparam int POS_W       = CNT_W + 2;
  localparam int STEP_W      = CNT_W + 1;
  localparam int IN_TDATA_W  = ((IDX_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] key;
  } hbil_req_t;

  typedef struct packed {
    logic             idle;
    logic             res_valid;
    logic [IDX_W-1:0] res_index;
  } hbil_sts_t;

endpackage

[rtl/hbil_engine.sv]
// key table memory and the hunt / bisection sequencer
`timescale 1ns / 1ps

module hbil_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  hbil_pkg::hbil_req_t req,
  input  logic [hbil_pkg::CNT_W-1:0] n_eff,
  input  logic              brk_clear,
  input  logic              res_ready,
  output hbil_pkg::hbil_sts_t sts
);
  import hbil_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LO0   = 9'b000000010,
    S_HIN   = 9'b000000100,
    S_HHI   = 9'b000001000,
    S_HLO   = 9'b000010000,
    S_CLAMP = 9'b000100000,
    S_BIS   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]        rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [POS_W-1:0] rd_pos;

  logic signed [KEY_W-1:0] tgt_r;
  logic signed [POS_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [IDX_W-1:0]        res_r, res_nxt;
  logic [IDX_W-1:0]        brk_lo_r, brk_hi_r;
  logic                    brk_vld_r;

  logic signed [POS_W-1:0] n_pos, nm1, step_s, pos_a, pos_b;
  logic                    lt, gt, brk_ok, mem_we;

  assign mem_we  = start && (req.func == FUNC_LOAD);
  assign rd_addr = rd_pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[req.entry_index] <= req.key;
    end
    rd_data <= key_mem[rd_addr];
  end

  assign lt     = tgt_r < $signed(rd_data);
  assign gt     = tgt_r > $signed(rd_data);
  assign n_pos  = $signed({2'b00, n_eff});
  assign nm1    = n_pos - POS_W'(1);
  assign step_s = $signed({1'b0, step_r});
  assign brk_ok = brk_vld_r && (CNT_W'(brk_hi_r) < n_eff) && (brk_lo_r <= brk_hi_r);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    step_nxt  = step_r;
    res_nxt   = res_r;
    rd_pos    = '0;
    pos_a     = '0;
    pos_b     = '0;
    case (state_r)
      S_IDLE: begin
        // key 0 is read while waiting so it is ready right after accept
        if (start && (req.func == FUNC_QUERY)) begin
          state_nxt = S_LO0;
        end
      end
      S_LO0: begin
        if (lt) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          rd_pos    = nm1;
          state_nxt = S_HIN;
        end
      end
      S_HIN: begin
        if (gt) begin
          res_nxt   = nm1[IDX_W-1:0];
          state_nxt = S_DONE;
        end else begin
          if (brk_ok) begin
            lo_nxt = $signed({{(POS_W-IDX_W){1'b0}}, brk_lo_r});
            hi_nxt = $signed({{(POS_W-IDX_W){1'b0}}, brk_hi_r});
          end else begin
            lo_nxt = '0;
            hi_nxt = nm1;
          end
          step_nxt  = STEP_W'(1);
          rd_pos    = hi_nxt;
          state_nxt = S_HHI;
        end
      end
      S_HHI: begin
        if (gt) begin
          lo_nxt   = hi_r;
          hi_nxt   = hi_r + step_s;
          step_nxt = step_r << 1;
          if (hi_nxt < n_pos) begin
            rd_pos = hi_nxt;
          end else begin
            state_nxt = S_CLAMP;
          end
        end else begin
          rd_pos    = lo_r;
          state_nxt = S_HLO;
        end
      end
      S_HLO: begin
        // once hunting down, the new high end is known to be above target
        if (lt) begin
          hi_nxt   = lo_r;
          lo_nxt   = lo_r - step_s;
          step_nxt = step_r << 1;
          if (lo_nxt >= 0) begin
            rd_pos = lo_nxt;
          end else begin
            state_nxt = S_CLAMP;
          end
        end else begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        hi_nxt = (hi_r > nm1) ? nm1 : hi_r;
        lo_nxt = (lo_r < 0) ? '0 : lo_r;
        pos_b  = hi_nxt - lo_nxt;
        if (pos_b > 1) begin
          pos_a     = lo_nxt + hi_nxt;
          rd_pos    = pos_a >>> 1;
          state_nxt = S_BIS;
        end else begin
          rd_pos    = hi_nxt;
          state_nxt = S_FIN;
        end
      end
      S_BIS: begin
        pos_a = (lo_r + hi_r) >>> 1;
        if (lt) begin
          hi_nxt = pos_a;
        end else begin
          lo_nxt = pos_a;
        end
        pos_b = hi_nxt - lo_nxt;
        if (pos_b > 1) begin
          rd_pos = (lo_nxt + hi_nxt) >>> 1;
        end else begin
          rd_pos    = hi_nxt;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_nxt   = lt ? lo_r[IDX_W-1:0] : hi_r[IDX_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      brk_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (brk_clear || mem_we) begin
        brk_vld_r <= 1'b0;
      end else if (state_r == S_FIN) begin
        brk_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tgt_r <= req.key;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
    // saved high end is the clamped hunt end, not where bisection stops
    if (state_r == S_CLAMP) begin
      brk_hi_r <= hi_nxt[IDX_W-1:0];
    end
    if (state_r == S_FIN) begin
      brk_lo_r <= res_nxt;
    end
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_DONE);
  assign sts.res_index = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("item accepted while a query is in flight");

  a_res_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_valid |-> (CNT_W'(res_r) < n_eff))
    else $error("result index beyond table count");

  a_fin_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> ((lo_r >= 0) && (lo_r <= hi_r) && (hi_r < n_pos)))
    else $error("final bracket not inside table");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !res_ready) |=> ((state_r == S_DONE) && $stable(res_r)))
    else $error("result dropped while stalled");

endmodule

[rtl/hunt_bisect_interval_locate.sv]
// top level: stream ports, table count register and result output stage
`timescale 1ns / 1ps
// a load beat is taken while idle and loads may follow back to back
// a query reads key 0 and then the last key, and ends there for a target outside
// the keys; else it hunts, clamps the bracket and bisects, one key table read per cycle
// the result sits in an output register; the next beat is taken while it waits
// reset clears control state and the bracket valid flag and sets the count to the table depth;
// key table contents are undefined until loaded and are never cleared

module hunt_bisect_interval_locate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index [9:0], key [41:10], zero pad above
  input  logic [hbil_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // lower_index [9:0], zero pad above
  output logic [hbil_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [hbil_pkg::CNT_W-1:0]       cfg_wr_data
);
  import hbil_pkg::*;

  hbil_req_t        req;
  hbil_sts_t        sts;
  logic             start, res_ready;
  logic [CNT_W-1:0] count_r, n_eff;
  logic             out_vld_r;
  logic [IDX_W-1:0] out_idx_r;

  assign req.func        = in_tuser;
  assign req.entry_index = in_tdata[IDX_W-1:0];
  assign req.key         = $signed(in_tdata[IDX_W+KEY_W-1:IDX_W]);

  assign in_tready = sts.idle;
  assign start     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // zero counts as one, anything past the depth as the depth
  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_r > CNT_W'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = count_r;
    end
  end

  hbil_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .n_eff     (n_eff),
    .brk_clear (cfg_wr_en),
    .res_ready (res_ready),
    .sts       (sts)
  );

  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (sts.res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_valid && res_ready) begin
      out_idx_r <= sts.res_index;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-IDX_W){1'b0}}, out_idx_r};

endmodule
